>>> rtl/c2p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c2p_pkg;

  localparam int C2P_ITERATIONS  = 16;
  localparam int C2P_COORD_WIDTH = 16;
  localparam int C2P_MAX_ITER    = 24;
  localparam int C2P_GUARD_BITS  = 24;
  localparam int C2P_ANG_FRAC    = 8;
  localparam int C2P_ANGLE_W     = 16;
  localparam int C2P_Z_W         = 26;
  localparam int C2P_XW_EXTRA    = C2P_GUARD_BITS + 3;
  localparam int C2P_TOL_W       = 15;

  typedef logic signed [C2P_Z_W-1:0] angle_acc_t;

  localparam logic [C2P_TOL_W-1:0] C2P_TOL_RESET = 15'd3;
  localparam angle_acc_t C2P_PI = angle_acc_t'(1) <<< (C2P_ANGLE_W - 1 + C2P_ANG_FRAC);

  localparam angle_acc_t C2P_ATAN [C2P_MAX_ITER] = '{
    26'sd2097152, 26'sd1238021, 26'sd654136, 26'sd332050,
    26'sd166669,  26'sd83416,   26'sd41718,  26'sd20860,
    26'sd10430,   26'sd5215,    26'sd2608,   26'sd1304,
    26'sd652,     26'sd326,     26'sd163,    26'sd81,
    26'sd41,      26'sd20,      26'sd10,     26'sd5,
    26'sd3,       26'sd1,       26'sd1,      26'sd0
  };

endpackage

`default_nettype wire

>>> rtl/c2p_front.sv
`timescale 1ns / 1ps
`default_nettype none

module c2p_front #(
  parameter int COORD_WIDTH = c2p_pkg::C2P_COORD_WIDTH
) (
  input  wire                                                   clk,
  input  wire                                                   rst,
  input  wire                                                   adv,
  input  wire                                                   in_valid,
  input  wire  signed [COORD_WIDTH-1:0]                         x_coord,
  input  wire  signed [COORD_WIDTH-1:0]                         y_coord,
  output logic                                                  out_valid,
  output logic signed [COORD_WIDTH+c2p_pkg::C2P_XW_EXTRA-1:0]   out_x,
  output logic signed [COORD_WIDTH+c2p_pkg::C2P_XW_EXTRA-1:0]   out_y,
  output c2p_pkg::angle_acc_t                                   out_z,
  output logic        [2*COORD_WIDTH:0]                         out_rad
);
  import c2p_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int XW  = CW + C2P_XW_EXTRA;
  localparam int EXT = XW - CW - 1 - C2P_GUARD_BITS;

  logic signed [CW:0] xs, ys, xn, yn;

  logic                 a_valid, b_valid, c_valid;
  logic [CW-1:0]        a_ax, a_ay;
  logic signed [CW:0]   a_x, a_y, b_x, b_y, c_x, c_y;
  angle_acc_t           a_z, b_z, c_z;
  logic [2*CW-1:0]      b_sqx, b_sqy;
  logic [2*CW:0]        c_rad;

  assign xs = {x_coord[CW-1], x_coord};
  assign ys = {y_coord[CW-1], y_coord};
  assign xn = -xs;
  assign yn = -ys;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ax <= x_coord[CW-1] ? xn[CW-1:0] : x_coord;
      a_ay <= y_coord[CW-1] ? yn[CW-1:0] : y_coord;
      if (x_coord[CW-1]) begin
        a_x <= xn;
        a_y <= yn;
        a_z <= ys[CW] ? -C2P_PI : C2P_PI;
      end else begin
        a_x <= xs;
        a_y <= ys;
        a_z <= '0;
      end

      b_sqx <= a_ax * a_ax;
      b_sqy <= a_ay * a_ay;
      b_x   <= a_x;
      b_y   <= a_y;
      b_z   <= a_z;

      c_rad <= {1'b0, b_sqx} + {1'b0, b_sqy};
      c_x   <= b_x;
      c_y   <= b_y;
      c_z   <= b_z;
    end
  end

  assign out_valid = c_valid;
  assign out_x     = {{EXT{c_x[CW]}}, c_x, {C2P_GUARD_BITS{1'b0}}};
  assign out_y     = {{EXT{c_y[CW]}}, c_y, {C2P_GUARD_BITS{1'b0}}};
  assign out_z     = c_z;
  assign out_rad   = c_rad;

endmodule

`default_nettype wire

>>> rtl/c2p_step.sv
`timescale 1ns / 1ps
`default_nettype none

module c2p_step #(
  parameter int COORD_WIDTH = c2p_pkg::C2P_COORD_WIDTH,
  parameter int STAGE       = 0,
  parameter int ROT_STEPS   = c2p_pkg::C2P_ITERATIONS
) (
  input  wire                                                   clk,
  input  wire                                                   rst,
  input  wire                                                   adv,
  input  wire                                                   in_valid,
  input  wire  signed [COORD_WIDTH+c2p_pkg::C2P_XW_EXTRA-1:0]   in_x,
  input  wire  signed [COORD_WIDTH+c2p_pkg::C2P_XW_EXTRA-1:0]   in_y,
  input  c2p_pkg::angle_acc_t                                   in_z,
  input  wire         [2*COORD_WIDTH:0]                         in_rem,
  input  wire         [COORD_WIDTH:0]                           in_root,
  output logic                                                  out_valid,
  output logic signed [COORD_WIDTH+c2p_pkg::C2P_XW_EXTRA-1:0]   out_x,
  output logic signed [COORD_WIDTH+c2p_pkg::C2P_XW_EXTRA-1:0]   out_y,
  output c2p_pkg::angle_acc_t                                   out_z,
  output logic        [2*COORD_WIDTH:0]                         out_rem,
  output logic        [COORD_WIDTH:0]                           out_root
);
  import c2p_pkg::*;

  localparam int XW = COORD_WIDTH + C2P_XW_EXTRA;
  localparam int RW = 2 * COORD_WIDTH + 1;
  localparam int DW = COORD_WIDTH + 1;

  logic signed [XW-1:0] x_next, y_next;
  angle_acc_t           z_next;
  logic [RW-1:0]        rem_next;
  logic [DW-1:0]        root_next;

  generate
    if (STAGE < ROT_STEPS) begin : g_rot
      logic signed [XW-1:0] dx, dy;
      assign dx = in_y >>> STAGE;
      assign dy = in_x >>> STAGE;
      always_comb begin
        x_next = in_x;
        y_next = in_y;
        z_next = in_z;
        if (!in_y[XW-1] && (in_y != '0)) begin
          x_next = in_x + dx;
          y_next = in_y - dy;
          z_next = in_z + C2P_ATAN[STAGE];
        end else if (in_y[XW-1]) begin
          x_next = in_x - dx;
          y_next = in_y + dy;
          z_next = in_z - C2P_ATAN[STAGE];
        end
      end
    end else begin : g_rot_pass
      assign x_next = in_x;
      assign y_next = in_y;
      assign z_next = in_z;
    end

    if (STAGE < DW) begin : g_sqrt
      localparam int B = COORD_WIDTH - STAGE;
      logic [RW:0] trial, rem_ext;
      assign trial   = ((RW+1)'(in_root) << (B + 1)) | ((RW+1)'(1) << (2 * B));
      assign rem_ext = {1'b0, in_rem};
      always_comb begin
        rem_next  = in_rem;
        root_next = in_root;
        if (rem_ext >= trial) begin
          rem_next  = RW'(rem_ext - trial);
          root_next = in_root | (DW'(1) << B);
        end
      end
    end else begin : g_sqrt_pass
      assign rem_next  = in_rem;
      assign root_next = in_root;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_rem  <= rem_next;
      out_root <= root_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/c2p_back.sv
`timescale 1ns / 1ps
`default_nettype none

module c2p_back #(
  parameter int COORD_WIDTH = c2p_pkg::C2P_COORD_WIDTH
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    adv,
  input  wire                                    in_valid,
  input  c2p_pkg::angle_acc_t                    in_z,
  input  wire         [2*COORD_WIDTH:0]          in_rem,
  input  wire         [COORD_WIDTH:0]            in_root,
  input  wire         [c2p_pkg::C2P_TOL_W-1:0]   tol,
  output logic                                   out_valid,
  output logic        [COORD_WIDTH:0]            distance,
  output logic signed [c2p_pkg::C2P_ANGLE_W-1:0] angle
);
  import c2p_pkg::*;

  localparam int RW = 2 * COORD_WIDTH + 1;
  localparam int DW = COORD_WIDTH + 1;
  localparam int AW = C2P_ANGLE_W;

  angle_acc_t    z_round;
  logic [AW-1:0] ang_raw;
  logic [AW:0]   ang_mag;
  logic [DW-1:0] dist_next;
  logic [AW-1:0] angle_next;

  assign z_round = in_z + (angle_acc_t'(1) <<< (C2P_ANG_FRAC - 1));
  assign ang_raw = z_round[C2P_ANG_FRAC +: AW];
  assign ang_mag = ang_raw[AW-1] ? (((AW+1)'(1) << AW) - {1'b0, ang_raw}) : {1'b0, ang_raw};

  always_comb begin
    dist_next  = (in_rem > RW'(in_root)) ? DW'(in_root + 1'b1) : in_root;
    angle_next = (ang_mag < (AW+1)'(tol)) ? '0 : ang_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      distance <= dist_next;
      angle    <= angle_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cartesian_to_polar.sv
`timescale 1ns / 1ps
`default_nettype none

// Cartesian to polar conversion, one vector per beat. The pipeline takes a new
// beat every cycle unless the output holds it: three front stages fold the
// vector and form x*x + y*y, then one stage per step resolves one bit of the
// square root, one CORDIC micro-rotation of the angle, or both side by side,
// and a last stage rounds both values into the output register. The whole pipe
// holds while a result sits unaccepted; in_ready is high whenever the output
// register is empty or being taken. angle is atan2 with 32768 for pi, and an
// angle below angle_tolerance in magnitude reads as zero (reset value 3).
module cartesian_to_polar #(
  parameter int ITERATIONS  = c2p_pkg::C2P_ITERATIONS,
  parameter int COORD_WIDTH = c2p_pkg::C2P_COORD_WIDTH
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_write_en,
  input  wire         [c2p_pkg::C2P_TOL_W-1:0]   cfg_write_data,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire  signed [COORD_WIDTH-1:0]          x_coord,
  input  wire  signed [COORD_WIDTH-1:0]          y_coord,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic        [COORD_WIDTH:0]            distance,
  output logic signed [c2p_pkg::C2P_ANGLE_W-1:0] angle
);
  import c2p_pkg::*;

  localparam int XW    = COORD_WIDTH + C2P_XW_EXTRA;
  localparam int RW    = 2 * COORD_WIDTH + 1;
  localparam int DW    = COORD_WIDTH + 1;
  localparam int ROT   = (ITERATIONS > C2P_MAX_ITER) ? C2P_MAX_ITER : ITERATIONS;
  localparam int STEPS = (ROT > DW) ? ROT : DW;

  logic                 adv;
  logic [C2P_TOL_W-1:0] angle_tolerance;

  logic                 st_valid [STEPS+1];
  logic signed [XW-1:0] st_x     [STEPS+1];
  logic signed [XW-1:0] st_y     [STEPS+1];
  angle_acc_t           st_z     [STEPS+1];
  logic [RW-1:0]        st_rem   [STEPS+1];
  logic [DW-1:0]        st_root  [STEPS+1];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_tolerance <= C2P_TOL_RESET;
    end else if (cfg_write_en) begin
      angle_tolerance <= cfg_write_data;
    end
  end

  c2p_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .out_valid (st_valid[0]),
    .out_x     (st_x[0]),
    .out_y     (st_y[0]),
    .out_z     (st_z[0]),
    .out_rad   (st_rem[0])
  );

  assign st_root[0] = '0;

  generate
    for (genvar i = 0; i < STEPS; i++) begin : g_step
      c2p_step #(
        .COORD_WIDTH (COORD_WIDTH),
        .STAGE       (i),
        .ROT_STEPS   (ROT)
      ) u_step (
        .clk       (clk),
        .rst       (rst),
        .adv       (adv),
        .in_valid  (st_valid[i]),
        .in_x      (st_x[i]),
        .in_y      (st_y[i]),
        .in_z      (st_z[i]),
        .in_rem    (st_rem[i]),
        .in_root   (st_root[i]),
        .out_valid (st_valid[i+1]),
        .out_x     (st_x[i+1]),
        .out_y     (st_y[i+1]),
        .out_z     (st_z[i+1]),
        .out_rem   (st_rem[i+1]),
        .out_root  (st_root[i+1])
      );
    end
  endgenerate

  c2p_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (st_valid[STEPS]),
    .in_z      (st_z[STEPS]),
    .in_rem    (st_rem[STEPS]),
    .in_root   (st_root[STEPS]),
    .tol       (angle_tolerance),
    .out_valid (out_valid),
    .distance  (distance),
    .angle     (angle)
  );

endmodule

`default_nettype wire

>>> rtl/c2p_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module c2p_checker #(
  parameter int COORD_WIDTH = c2p_pkg::C2P_COORD_WIDTH
) (
  input wire                                    clk,
  input wire                                    rst,
  input wire                                    cfg_write_en,
  input wire         [c2p_pkg::C2P_TOL_W-1:0]   cfg_write_data,
  input wire                                    in_valid,
  input wire                                    in_ready,
  input wire  signed [COORD_WIDTH-1:0]          x_coord,
  input wire  signed [COORD_WIDTH-1:0]          y_coord,
  input wire                                    out_valid,
  input wire                                    out_ready,
  input wire         [COORD_WIDTH:0]            distance,
  input wire  signed [c2p_pkg::C2P_ANGLE_W-1:0] angle
);
  import c2p_pkg::*;

  localparam int AW = C2P_ANGLE_W;

  logic [C2P_TOL_W-1:0] tol_seen;
  logic [AW:0]          ang_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol_seen <= C2P_TOL_RESET;
    end else if (cfg_write_en) begin
      tol_seen <= cfg_write_data;
    end
  end

  assign ang_mag = angle[AW-1] ? (((AW+1)'(1) << AW) - {1'b0, angle}) : {1'b0, angle};

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(x_coord) && $stable(y_coord))
    else $error("stalled input beat changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(angle))
    else $error("stalled result changed");

  a_tol_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (angle != '0) |-> ang_mag >= (AW+1)'(tol_seen))
    else $error("angle inside tolerance not zeroed");

endmodule

bind cartesian_to_polar c2p_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_c2p_checker (
  .clk            (clk),
  .rst            (rst),
  .cfg_write_en   (cfg_write_en),
  .cfg_write_data (cfg_write_data),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .x_coord        (x_coord),
  .y_coord        (y_coord),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .distance       (distance),
  .angle          (angle)
);

`default_nettype wire

>>> dv/cartesian_to_polar_checker.sv
`timescale 1ns / 1ps

module cartesian_to_polar_checker (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_write_en,
  input  wire         [c2p_pkg::C2P_TOL_W-1:0]   cfg_write_data,
  input  wire                                    in_valid,
  input  wire                                    in_ready,
  input  wire  signed [c2p_pkg::C2P_COORD_WIDTH-1:0] x_coord,
  input  wire  signed [c2p_pkg::C2P_COORD_WIDTH-1:0] y_coord,
  input  wire                                    out_valid,
  input  wire                                    out_ready,
  input  wire         [c2p_pkg::C2P_COORD_WIDTH:0]   distance,
  input  wire  signed [c2p_pkg::C2P_ANGLE_W-1:0] angle,
  output int                                     mismatch_count,
  output int                                     pending_count,
  output int                                     checked_count
);

  localparam int CW = c2p_pkg::C2P_COORD_WIDTH;
  localparam int AW = c2p_pkg::C2P_ANGLE_W;
  localparam int TW = c2p_pkg::C2P_TOL_W;
  localparam int ROTATIONS = (c2p_pkg::C2P_ITERATIONS > 24) ? 24 : c2p_pkg::C2P_ITERATIONS;
  localparam int SCALE_SHIFT = 24;
  localparam int FRAC_BITS = 8;
  localparam longint HALF_TURN = longint'(1) << 23;
  localparam logic [TW-1:0] TOLERANCE_AT_RESET = 15'd3;
  localparam longint ARCTAN_STEP [24] = '{
    64'sd2097152, 64'sd1238021, 64'sd654136, 64'sd332050,
    64'sd166669,  64'sd83416,   64'sd41718,  64'sd20860,
    64'sd10430,   64'sd5215,    64'sd2608,   64'sd1304,
    64'sd652,     64'sd326,     64'sd163,    64'sd81,
    64'sd41,      64'sd20,      64'sd10,     64'sd5,
    64'sd3,       64'sd1,       64'sd1,      64'sd0
  };

  typedef struct packed {
    logic        [CW:0]   radius;
    logic signed [AW-1:0] ang;
  } polar_t;

  polar_t        expected_polar [$];
  polar_t        seen;
  polar_t        want;
  logic [TW-1:0] tolerance;

  function automatic polar_t predict_polar(input logic signed [CW-1:0] x_in,
                                           input logic signed [CW-1:0] y_in,
                                           input logic [TW-1:0] tol);
    longint      xs;
    longint      ys;
    longint      zs;
    longint      dx;
    longint      dy;
    longint      sq;
    longint      rem;
    longint      root;
    longint      bitv;
    logic [AW-1:0] ang_bits;
    logic [AW:0]   mag;
    polar_t      r;
    xs = x_in;
    ys = y_in;
    sq = xs * xs + ys * ys;
    rem = sq;
    root = 0;
    bitv = longint'(1) << 40;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (sq - root * root > root) root = root + 1;
    zs = 0;
    if (xs != 0 || ys != 0) begin
      if (xs < 0) begin
        zs = (ys >= 0) ? HALF_TURN : -HALF_TURN;
        xs = -xs;
        ys = -ys;
      end
      xs = xs <<< SCALE_SHIFT;
      ys = ys <<< SCALE_SHIFT;
      for (int i = 0; i < ROTATIONS; i++) begin
        dx = ys >>> i;
        dy = xs >>> i;
        if (ys > 0) begin
          xs = xs + dx;
          ys = ys - dy;
          zs = zs + ARCTAN_STEP[i];
        end else if (ys < 0) begin
          xs = xs - dx;
          ys = ys + dy;
          zs = zs - ARCTAN_STEP[i];
        end
      end
    end
    ang_bits = AW'((zs + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
    mag = ang_bits[AW-1] ? ((AW+1)'(1) << AW) - {1'b0, ang_bits} : {1'b0, ang_bits};
    if (mag < tol) ang_bits = '0;
    r.radius = root[CW:0];
    r.ang = ang_bits;
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatch_count < 10)
      $display("mismatch (%s): expected distance %0d angle %0d, got distance %0d angle %0d",
               what, want.radius, want.ang, seen.radius, seen.ang);
    mismatch_count++;
  endtask

  initial begin
    mismatch_count = 0;
    pending_count = 0;
    checked_count = 0;
    tolerance = TOLERANCE_AT_RESET;
  end

  // Sample on the falling edge before the rising edge that completes each beat.
  always @(negedge clk) begin
    if (rst) begin
      tolerance = TOLERANCE_AT_RESET;
      expected_polar.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen.radius = distance;
        seen.ang = angle;
        if (expected_polar.size() == 0) begin
          want = '0;
          note_mismatch("unexpected beat");
        end else begin
          want = expected_polar.pop_front();
          checked_count++;
          if (seen !== want) note_mismatch("wrong value");
        end
      end
      if (cfg_write_en) tolerance = cfg_write_data;
      if (in_valid && in_ready)
        expected_polar.push_back(predict_polar(x_coord, y_coord, tolerance));
    end
    pending_count = expected_polar.size();
  end

endmodule

>>> dv/cartesian_to_polar_test.sv
`timescale 1ns / 1ps

module cartesian_to_polar_test;

  localparam int CW = c2p_pkg::C2P_COORD_WIDTH;
  localparam int AW = c2p_pkg::C2P_ANGLE_W;
  localparam int TW = c2p_pkg::C2P_TOL_W;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic        [TW-1:0] cfg_write_data = '0;
  logic                 in_valid = 1'b0;
  logic signed [CW-1:0] x_coord = '0;
  logic signed [CW-1:0] y_coord = '0;
  logic                 out_ready = 1'b0;
  wire                  in_ready;
  wire                  out_valid;
  wire         [CW:0]   distance;
  wire  signed [AW-1:0] angle;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int send_idle_pct = 6;
  int recv_idle_pct = 84;
  int vectors_sent = 0;
  int tolerance_writes = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;

  cartesian_to_polar dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .x_coord        (x_coord),
    .y_coord        (y_coord),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .distance       (distance),
    .angle          (angle)
  );

  cartesian_to_polar_checker checker_0 (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .x_coord        (x_coord),
    .y_coord        (y_coord),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .distance       (distance),
    .angle          (angle),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_vector(input int x, input int y);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_coord <= x[CW-1:0];
    y_coord <= y[CW-1:0];
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    vectors_sent++;
  endtask

  task automatic write_tolerance(input int value);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value[TW-1:0];
    @(posedge clk);
    cfg_write_en <= 1'b0;
    tolerance_writes++;
  endtask

  task automatic random_vector(output int x, output int y);
    int kind;
    int m;
    kind = $urandom_range(0, 9);
    x = int'($urandom_range(0, 65535)) - 32768;
    y = int'($urandom_range(0, 65535)) - 32768;
    case (kind)
      5: begin
        x = int'($urandom_range(0, 31)) - 16;
        y = int'($urandom_range(0, 31)) - 16;
      end
      6: begin
        if ($urandom_range(0, 1) == 1) y = 0;
        else x = 0;
      end
      7: begin
        x = -int'($urandom_range(16384, 32768));
        y = int'($urandom_range(0, 6)) - 3;
      end
      8: begin
        x = $urandom_range(1, 32767);
        y = int'($urandom_range(0, 40)) - 20;
      end
      9: begin
        m = $urandom_range(0, 32767);
        x = ($urandom_range(0, 1) == 1) ? -m : m;
        y = ($urandom_range(0, 1) == 1) ? -m : m;
      end
      default: ;
    endcase
  endtask

  task automatic run_random(input int count, input int send_pct, input int recv_pct);
    int x;
    int y;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      random_vector(x, y);
      send_vector(x, y);
    end
  endtask

  task automatic run_directed();
    send_vector(0, 0);
    send_vector(1, 0);
    send_vector(-1, 0);
    send_vector(0, 1);
    send_vector(0, -1);
    send_vector(32767, 0);
    send_vector(-32768, 0);
    send_vector(0, 32767);
    send_vector(0, -32768);
    send_vector(32767, 32767);
    send_vector(-32768, -32768);
    send_vector(-32768, 32767);
    send_vector(32767, -32768);
    send_vector(-32768, 1);
    send_vector(-32768, -1);
    send_vector(-1, -1);
    send_vector(1, 1);
    send_vector(10430, 2);
    send_vector(10430, 3);
    send_vector(10430, -3);
    send_vector(32767, 1);
    send_vector(-1, 32767);
  endtask

  // Receiver: random backpressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_count);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    write_tolerance(0);
    run_random(200, 6, 84);
    write_tolerance(32767);
    run_random(200, 84, 6);
    write_tolerance($urandom_range(1, 64));
    hold_request = 1'b1;
    run_random(200, 0, 0);
    write_tolerance($urandom_range(0, 32767));
    run_random(200, 0, 0);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Converted %0d vectors (axes, extremes, pi wrap, tolerance edges, random) under %0d tolerance settings",
             vectors_sent, tolerance_writes + 1);
    $display("Checked %0d results with %0d mismatches, including a %0d-cycle output stall",
             checked_count, mismatch_count, HOLD_CYCLES);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
